@@ sv/btmx_pkg.sv @@
// Shared types, sizes, codes and link helpers for the binary trie max-XOR block.
package btmx_pkg;

  localparam int KEY_BITS   = 32;
  localparam int NODE_SLOTS = 65536;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int NODE_W     = $clog2(NODE_SLOTS);
  localparam int USED_W     = NODE_W + 1;
  localparam int LVL_W      = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef logic [NODE_W-1:0] node_idx_t;

  typedef struct packed {
    node_idx_t l1;
    node_idx_t l0;
  } links_t;

  typedef struct packed {
    logic               action;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  max_xor;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  function automatic node_idx_t link_of(input links_t w, input logic b);
    return b ? w.l1 : w.l0;
  endfunction

  function automatic links_t set_link(input links_t w, input logic b, input node_idx_t v);
    links_t r;
    r = w;
    if (b) begin
      r.l1 = v;
    end else begin
      r.l0 = v;
    end
    return r;
  endfunction

endpackage

@@ sv/btmx_cell.sv @@
// One bit cell of the operand/result shift row.
module btmx_cell (
  input  logic clk,
  input  logic load,
  input  logic shift,
  input  logic load_bit,
  input  logic key_in,
  input  logic best_in,
  output logic key_out,
  output logic best_out
);

  logic key_r;
  logic best_r;

  always_ff @(posedge clk) begin
    if (load) begin
      key_r  <= load_bit;
      best_r <= 1'b0;
    end else if (shift) begin
      key_r  <= key_in;
      best_r <= best_in;
    end
  end

  assign key_out  = key_r;
  assign best_out = best_r;

endmodule

@@ sv/btmx_node_store.sv @@
// Node store: child link pairs, one write and one registered read per cycle.
module btmx_node_store (
  input  logic              clk,
  input  logic              we,
  input  btmx_pkg::node_idx_t waddr,
  input  btmx_pkg::links_t    wdata,
  input  btmx_pkg::node_idx_t raddr,
  output btmx_pkg::links_t    rdata
);

  btmx_pkg::links_t mem [btmx_pkg::NODE_SLOTS];
  btmx_pkg::links_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/binary_trie_max_xor.sv @@
// Binary trie of keys answering maximum-XOR queries; top level with walk control.
// A request is taken when start is high and busy is low; one result follows as a
// single-cycle out_valid strobe and cannot be held off. The trie is walked one level
// per cycle through the node store's registered read port. A query on an empty trie
// answers from the idle state without a walk. An insert follows the stored prefix;
// a key already stored ends there, otherwise one node is allocated per missing level
// and the leaf is cleared, or the insert is refused with ST_FULL where the prefix
// ends if too few free slots remain. A new request can be taken in the cycle its
// predecessor's result is shown. Nodes are handed out in order and written when
// allocated, so the store needs no clearing pass after reset; the root's links live
// in flip-flops.
module binary_trie_max_xor (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  btmx_pkg::in_item_t  in_item,
  output logic                busy,
  output logic                out_valid,
  output btmx_pkg::out_item_t out_item
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_QRY   = 3'd1;
  localparam logic [2:0] S_FIND  = 3'd2;
  localparam logic [2:0] S_ALLOC = 3'd3;
  localparam logic [2:0] S_LEAF  = 3'd4;

  logic [2:0]                      state_r, state_nxt;
  logic [btmx_pkg::LVL_W-1:0]      lvl_r, lvl_nxt;
  logic                            at_root_r, at_root_nxt;
  logic                            dead_r, dead_nxt;
  logic                            first_r, first_nxt;
  logic                            prev_root_r, prev_root_nxt;
  btmx_pkg::node_idx_t             prev_r, prev_nxt;
  btmx_pkg::links_t                par_word_r, par_word_nxt;
  btmx_pkg::links_t                root_r, root_nxt;
  logic [btmx_pkg::USED_W-1:0]     used_r, used_nxt;
  logic                            has_keys_r, has_keys_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [btmx_pkg::STATUS_W-1:0]   status_r, status_nxt;

  logic                            accept;
  logic                            cell_load;
  logic                            cell_shift;
  logic                            new_bit;
  logic                            cur_bit;
  btmx_pkg::links_t                cur_word;
  btmx_pkg::links_t                rdata;
  btmx_pkg::node_idx_t             raddr;
  logic                            we;
  btmx_pkg::links_t                wdata;
  btmx_pkg::node_idx_t             opp_link;
  btmx_pkg::node_idx_t             same_link;
  logic [btmx_pkg::USED_W-1:0]     missing;
  logic [btmx_pkg::USED_W-1:0]     free_slots;
  logic [btmx_pkg::VALUE_W-1:0]    max_xor_w;

  logic [btmx_pkg::KEY_BITS-1:0]   key_q;
  logic [btmx_pkg::KEY_BITS-1:0]   best_q;
  logic [btmx_pkg::KEY_BITS-1:0]   load_bits;

  // Shift row: the top cell presents the bit for the current level.
  for (genvar i = 0; i < btmx_pkg::KEY_BITS; i++) begin : g_cell
    if (i < btmx_pkg::VALUE_W) begin : g_ld
      assign load_bits[i] = in_item.value[i];
    end else begin : g_ld0
      assign load_bits[i] = 1'b0;
    end
    if (i == 0) begin : g_first
      btmx_cell u_cell (
        .clk      (clk),
        .load     (cell_load),
        .shift    (cell_shift),
        .load_bit (load_bits[i]),
        .key_in   (1'b0),
        .best_in  (new_bit),
        .key_out  (key_q[i]),
        .best_out (best_q[i])
      );
    end else begin : g_rest
      btmx_cell u_cell (
        .clk      (clk),
        .load     (cell_load),
        .shift    (cell_shift),
        .load_bit (load_bits[i]),
        .key_in   (key_q[i-1]),
        .best_in  (best_q[i-1]),
        .key_out  (key_q[i]),
        .best_out (best_q[i])
      );
    end
  end

  for (genvar j = 0; j < btmx_pkg::VALUE_W; j++) begin : g_out
    if (j < btmx_pkg::KEY_BITS) begin : g_b
      assign max_xor_w[j] = best_q[j];
    end else begin : g_z
      assign max_xor_w[j] = 1'b0;
    end
  end

  btmx_node_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (prev_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cell_load = accept;
  assign cur_bit   = key_q[btmx_pkg::KEY_BITS-1];
  assign cur_word  = at_root_r ? root_r : rdata;
  assign opp_link  = btmx_pkg::link_of(cur_word, ~cur_bit);
  assign same_link = btmx_pkg::link_of(cur_word, cur_bit);
  assign missing   = btmx_pkg::USED_W'(lvl_r) + btmx_pkg::USED_W'(1);
  assign free_slots = btmx_pkg::USED_W'(btmx_pkg::NODE_SLOTS) - used_r;

  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    at_root_nxt   = at_root_r;
    dead_nxt      = dead_r;
    first_nxt     = first_r;
    prev_root_nxt = prev_root_r;
    prev_nxt      = prev_r;
    par_word_nxt  = par_word_r;
    root_nxt      = root_r;
    used_nxt      = used_r;
    has_keys_nxt  = has_keys_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    cell_shift    = 1'b0;
    new_bit       = 1'b0;
    raddr         = same_link;
    we            = 1'b0;
    wdata         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          lvl_nxt     = btmx_pkg::LVL_W'(btmx_pkg::KEY_BITS - 1);
          at_root_nxt = 1'b1;
          dead_nxt    = 1'b0;
          if (in_item.action == btmx_pkg::ACT_INSERT) begin
            state_nxt = S_FIND;
          end else if (has_keys_r) begin
            state_nxt = S_QRY;
          end else begin
            out_valid_nxt = 1'b1;
            status_nxt    = btmx_pkg::ST_EMPTY;
          end
        end
      end
      S_QRY: begin
        // Prefer the opposite bit; a dead walk keeps shifting zeros.
        cell_shift  = 1'b1;
        at_root_nxt = 1'b0;
        if (!dead_r && (opp_link != '0)) begin
          new_bit = 1'b1;
          raddr   = opp_link;
        end else if (!dead_r && (same_link == '0)) begin
          dead_nxt = 1'b1;
        end
        if (lvl_r == '0) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = btmx_pkg::ST_OK;
        end else begin
          lvl_nxt = lvl_r - btmx_pkg::LVL_W'(1);
        end
      end
      S_FIND: begin
        if (same_link != '0) begin
          cell_shift  = 1'b1;
          at_root_nxt = 1'b0;
          prev_nxt    = same_link;
          if (lvl_r == '0) begin
            // Key already stored.
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
            status_nxt    = btmx_pkg::ST_OK;
            has_keys_nxt  = 1'b1;
          end else begin
            lvl_nxt = lvl_r - btmx_pkg::LVL_W'(1);
          end
        end else if (missing > free_slots) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = btmx_pkg::ST_FULL;
        end else begin
          state_nxt     = S_ALLOC;
          par_word_nxt  = cur_word;
          prev_root_nxt = at_root_r;
          first_nxt     = 1'b1;
        end
      end
      S_ALLOC: begin
        // Link the previous node to a fresh one, then step down.
        wdata = btmx_pkg::set_link(first_r ? par_word_r : '0, cur_bit,
                                   used_r[btmx_pkg::NODE_W-1:0]);
        if (prev_root_r) begin
          root_nxt = wdata;
        end else begin
          we = 1'b1;
        end
        cell_shift    = 1'b1;
        first_nxt     = 1'b0;
        prev_root_nxt = 1'b0;
        prev_nxt      = used_r[btmx_pkg::NODE_W-1:0];
        used_nxt      = used_r + btmx_pkg::USED_W'(1);
        if (lvl_r == '0) begin
          state_nxt = S_LEAF;
        end else begin
          lvl_nxt = lvl_r - btmx_pkg::LVL_W'(1);
        end
      end
      S_LEAF: begin
        we            = 1'b1;
        wdata         = '0;
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        status_nxt    = btmx_pkg::ST_OK;
        has_keys_nxt  = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      root_r      <= '0;
      used_r      <= btmx_pkg::USED_W'(1);
      has_keys_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prev_root_r <= 1'b0;
      first_r     <= 1'b0;
      at_root_r   <= 1'b0;
      dead_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      root_r      <= root_nxt;
      used_r      <= used_nxt;
      has_keys_r  <= has_keys_nxt;
      out_valid_r <= out_valid_nxt;
      prev_root_r <= prev_root_nxt;
      first_r     <= first_nxt;
      at_root_r   <= at_root_nxt;
      dead_r      <= dead_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r      <= lvl_nxt;
    prev_r     <= prev_nxt;
    par_word_r <= par_word_nxt;
    status_r   <= status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_item.max_xor = max_xor_w;
  assign out_item.status  = status_r;

  a_out_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while a request is still in progress");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= btmx_pkg::USED_W'(btmx_pkg::NODE_SLOTS))
    else $error("node count beyond store size");

  a_empty_only_without_keys: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status == btmx_pkg::ST_EMPTY)) |-> !has_keys_r)
    else $error("empty status reported while keys are stored");

  a_root_first_level: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_QRY || state_r == S_FIND) && at_root_r)
      |-> (lvl_r == btmx_pkg::LVL_W'(btmx_pkg::KEY_BITS - 1)))
    else $error("root used below the top level");

  a_write_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_ALLOC || state_r == S_LEAF))
    else $error("node store written outside allocation");

endmodule
